// ----- rtl/rgba_blit_pixel_packer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RGBA blit pixel packer
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGBA_BLIT_PIXEL_PACKER_ASSERT_SVH
`define RGBA_BLIT_PIXEL_PACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBPP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rbpp same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RBPP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rbpp next-cycle assertion failed");

`endif

// ----- rtl/rbpp_pkg.sv -----
// ----------------------------------------------------------------------------
// RGBA blit pixel packer package
// Sizes, register indexes and the channel placement function.
// ----------------------------------------------------------------------------
package rbpp_pkg;

   localparam int MAX_WIDTH  = 8192;
   localparam int MAX_HEIGHT = 8192;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
   localparam int CHAN_W  = 8;
   localparam int DIM_W   = 14;
   localparam int PITCH_W = 16;
   localparam int BPP_W   = 7;
   localparam int LAY_W   = 9;
   localparam int OFFS_W  = 29;
   localparam int WORD_W  = 32;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [BPP_W-1:0] BPP_32 = 7'd32;
   localparam logic [BPP_W-1:0] BPP_24 = 7'd24;
   localparam logic [3:0]       MASK_FULL = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_ROW_PITCH     = 3'd2,
      CSR_BITS_PER_PIX  = 3'd3,
      CSR_RED_LAYOUT    = 3'd4,
      CSR_GREEN_LAYOUT  = 3'd5,
      CSR_BLUE_LAYOUT   = 3'd6,
      CSR_IMAGE_WIDTH   = 3'd7
   } csr_index_type;

   // Keeps the top bits of a channel as given by the mask size, then moves
   // them to the channel position. Sizes above eight act as eight.
   function automatic logic [WORD_W-1:0] channel_place(input logic [CHAN_W-1:0] value,
                                                       input logic [LAY_W-1:0] layout);
      logic [3:0]        size;
      logic [CHAN_W-1:0] kept;
      size = (layout[3:0] > MASK_FULL) ? MASK_FULL : layout[3:0];
      kept = value >> (MASK_FULL - size);
      return WORD_W'(kept) << layout[8:4];
   endfunction

endpackage

// ----- rtl/rgba_blit_pixel_packer.sv -----
// ----------------------------------------------------------------------------
// RGBA blit pixel packer
// Turns a row-major stream of RGB pixels into clipped framebuffer writes.
// ----------------------------------------------------------------------------
// Usage:
//   Source pixels enter on the req_ channel (valid/stall), one item per pixel
//   in row-major order; req_last_pixel marks the final pixel of an image.
//   Each pixel that lands inside the visible framebuffer at a depth of 24 or
//   32 bits gives one item on the rsp_ channel: a byte offset from the
//   framebuffer base, the packed pixel word and a four-byte flag. Clipped
//   pixels and other depths give no item, but still advance the position.
//   Registers are written through the csr_ port while the block is idle.
//   An accepted item passes the input register, then the result register,
//   before it shows on the rsp_ ports. Throughput is one item per cycle when
//   rsp_stall is low, set by the two-stage pipeline of an input register and
//   a result register, with the offset multiplier between them.
//   When the receiver stalls, the result register holds its item and the
//   input stage fills; req_stall rises only while both are occupied.
//   Synchronous reset empties the pipeline, clears the column and row
//   counters and returns all configuration registers to zero, except image_width to one.
// ----------------------------------------------------------------------------
`include "rgba_blit_pixel_packer_assert.svh"

module rgba_blit_pixel_packer
   import rbpp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CHAN_W-1:0]    req_red,
   input  logic [CHAN_W-1:0]    req_green,
   input  logic [CHAN_W-1:0]    req_blue,
   input  logic                 req_last_pixel,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [OFFS_W-1:0]    rsp_byte_offset,
   output logic [WORD_W-1:0]    rsp_pixel_word,
   output logic                 rsp_four_bytes,

   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   // Configuration registers.
   logic [DIM_W-1:0]   screen_width_ff, screen_height_ff, image_width_ff;
   logic [PITCH_W-1:0] row_pitch_ff;
   logic [BPP_W-1:0]   bpp_ff;
   logic [LAY_W-1:0]   red_layout_ff, green_layout_ff, blue_layout_ff;

   // Position counters.
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   // Input stage: holds only pixels that produce a write.
   logic               s1_valid_ff, s1_valid_in;
   logic [CHAN_W-1:0]  s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;

   // Result stage.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OFFS_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [WORD_W-1:0]  rsp_word_ff, rsp_word_in;
   logic               rsp_four_ff, rsp_four_in;

   logic               req_accept;
   logic               out_free;
   logic               s1_load;
   logic               hit;
   logic [COL_W:0]     col_next;
   logic [ROW_W+PITCH_W-1:0] row_bytes;
   logic [COL_W+1:0]   col_bytes;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // The input stage takes a new item when it is empty or its item moves on.
   assign s1_load    = !s1_valid_ff || out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign hit = (32'(col_ff) < 32'(screen_width_ff)) &&
                (32'(row_ff) < 32'(screen_height_ff)) &&
                ((bpp_ff == BPP_32) || (bpp_ff == BPP_24));

   // The column wraps when the next column reaches the image width or the
   // largest supported width; the row stops once it reaches the height limit.
   always_comb begin
      col_next = {1'b0, col_ff} + 1'b1;
      col_in   = col_ff;
      row_in   = row_ff;
      if (req_accept) begin
         if (req_last_pixel) begin
            col_in = '0;
            row_in = '0;
         end else if ((32'(col_next) >= 32'(image_width_ff)) ||
                      (32'(col_next) >= 32'(MAX_WIDTH))) begin
            col_in = '0;
            if (32'(row_ff) < 32'(MAX_HEIGHT)) begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_comb begin
      if (s1_load) begin
         s1_valid_in = req_accept && hit;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Offset and packing for the item in the input stage.
   always_comb begin
      row_bytes = ROW_W'(s1_row_ff) * row_pitch_ff;
      if (bpp_ff == BPP_32) begin
         col_bytes = {s1_col_ff, 2'b00};
      end else begin
         col_bytes = {1'b0, s1_col_ff, 1'b0} + (COL_W+2)'(s1_col_ff);
      end
      rsp_offset_in = OFFS_W'(row_bytes) + OFFS_W'(col_bytes);
      if ((red_layout_ff[3:0] == 4'd0) && (green_layout_ff[3:0] == 4'd0) &&
          (blue_layout_ff[3:0] == 4'd0)) begin
         rsp_word_in = {8'h00, s1_red_ff, s1_green_ff, s1_blue_ff};
      end else begin
         rsp_word_in = channel_place(s1_red_ff, red_layout_ff) |
                       channel_place(s1_green_ff, green_layout_ff) |
                       channel_place(s1_blue_ff, blue_layout_ff);
      end
      rsp_four_in = (bpp_ff == BPP_32);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= '0;
         screen_height_ff <= '0;
         row_pitch_ff     <= '0;
         bpp_ff           <= '0;
         red_layout_ff    <= '0;
         green_layout_ff  <= '0;
         blue_layout_ff   <= '0;
         image_width_ff   <= DIM_W'(1);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data[DIM_W-1:0];
            CSR_ROW_PITCH:     row_pitch_ff     <= csr_data[PITCH_W-1:0];
            CSR_BITS_PER_PIX:  bpp_ff           <= csr_data[BPP_W-1:0];
            CSR_RED_LAYOUT:    red_layout_ff    <= csr_data[LAY_W-1:0];
            CSR_GREEN_LAYOUT:  green_layout_ff  <= csr_data[LAY_W-1:0];
            CSR_BLUE_LAYOUT:   blue_layout_ff   <= csr_data[LAY_W-1:0];
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_red_ff   <= req_red;
         s1_green_ff <= req_green;
         s1_blue_ff  <= req_blue;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
      end
      if (out_free && s1_valid_ff) begin
         rsp_offset_ff <= rsp_offset_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_four_ff   <= rsp_four_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_offset = rsp_offset_ff;
   assign rsp_pixel_word  = rsp_word_ff;
   assign rsp_four_bytes  = rsp_four_ff;

   `RBPP_ASSERT_SAME(a_row_saturates, 1'b1, 32'(row_ff) <= 32'(MAX_HEIGHT))
   `RBPP_ASSERT_NEXT(a_last_clears, req_accept && req_last_pixel,
                     (col_ff == '0) && (row_ff == '0))
   `RBPP_ASSERT_NEXT(a_stage_moves, s1_valid_ff && out_free, rsp_valid_ff)
   `RBPP_ASSERT_SAME(a_four_matches, rsp_valid_ff, rsp_four_ff == (bpp_ff == BPP_32))

endmodule

// ----- sim/rgba_blit_pixel_packer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGBA blit pixel packer testbench
// Streams source pixels through the packer under several framebuffer setups
// and checks every write item against a cycle-free model of the packer that
// tracks the column and row position and composes the pixel word itself.
// ----------------------------------------------------------------------------
module rgba_blit_pixel_packer_test;
   import rbpp_pkg::*;

   typedef struct {
      logic [DIM_W-1:0]   screen_width;
      logic [DIM_W-1:0]   screen_height;
      logic [PITCH_W-1:0] row_pitch;
      logic [BPP_W-1:0]   depth;
      logic [LAY_W-1:0]   red_layout;
      logic [LAY_W-1:0]   green_layout;
      logic [LAY_W-1:0]   blue_layout;
      logic [DIM_W-1:0]   image_width;
   } fb_regs_type;

   typedef struct {
      logic [OFFS_W-1:0] byte_offset;
      logic [WORD_W-1:0] pixel_word;
      logic              four_bytes;
   } fb_write_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CHAN_W-1:0]    req_red = '0;
   logic [CHAN_W-1:0]    req_green = '0;
   logic [CHAN_W-1:0]    req_blue = '0;
   logic                 req_last_pixel = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [OFFS_W-1:0]    rsp_byte_offset;
   logic [WORD_W-1:0]    rsp_pixel_word;
   logic                 rsp_four_bytes;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   // Register copy and source position as the packer should hold them.
   fb_regs_type          fb = '{default: '0, image_width: 1};
   logic [COL_W-1:0]     cur_col = '0;
   logic [ROW_W-1:0]     cur_row = '0;

   fb_write_type         pending_writes[$];
   fb_write_type         oldest_write;
   int                   error_count = 0;
   bit                   send_gaps_on = 1'b1;
   bit                   stall_bursts_on = 1'b1;

   rgba_blit_pixel_packer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_last_pixel  (req_last_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_pixel_word  (rsp_pixel_word),
      .rsp_four_bytes  (rsp_four_bytes),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Receiver backpressure in random bursts.
   initial begin
      forever begin
         @(negedge clock);
         if (stall_bursts_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [WORD_W-1:0] place_channel(input logic [CHAN_W-1:0] level,
                                                       input logic [LAY_W-1:0] layout);
      int unsigned keep;
      keep = layout[3:0];
      if (keep > 8) keep = 8;
      return (WORD_W'(level) >> (8 - keep)) << layout[8:4];
   endfunction

   function automatic logic [WORD_W-1:0] compose_word(input logic [CHAN_W-1:0] r, g, b);
      if (fb.red_layout[3:0] == 0 && fb.green_layout[3:0] == 0 && fb.blue_layout[3:0] == 0)
         return {8'h00, r, g, b};
      return place_channel(r, fb.red_layout) | place_channel(g, fb.green_layout) |
             place_channel(b, fb.blue_layout);
   endfunction

   // Works out the write caused by one accepted pixel and moves the position on.
   task automatic track_pixel(input logic [CHAN_W-1:0] r, g, b, input logic last);
      logic [47:0]  offs;
      fb_write_type wr;
      int unsigned  next_col;
      if (cur_col < fb.screen_width && cur_row < fb.screen_height &&
          (fb.depth == BPP_32 || fb.depth == BPP_24)) begin
         offs = 48'(cur_row) * 48'(fb.row_pitch) + 48'(cur_col) * 48'(fb.depth >> 3);
         wr.byte_offset = offs[OFFS_W-1:0];
         wr.pixel_word  = compose_word(r, g, b);
         wr.four_bytes  = (fb.depth == BPP_32);
         pending_writes.push_back(wr);
      end
      if (last) begin
         cur_col = '0;
         cur_row = '0;
      end else begin
         next_col = int'(cur_col) + 1;
         if (next_col >= fb.image_width || next_col >= MAX_WIDTH) begin
            cur_col = '0;
            if (cur_row < MAX_HEIGHT) cur_row = cur_row + 1'b1;
         end else begin
            cur_col = next_col[COL_W-1:0];
         end
      end
   endtask

   task automatic stream_pixel(input logic [CHAN_W-1:0] r, g, b, input logic last);
      @(negedge clock);
      if (send_gaps_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_red        <= r;
      req_green      <= g;
      req_blue       <= b;
      req_last_pixel <= last;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      track_pixel(r, g, b, last);
   endtask

   task automatic drain_results();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   // Clipped pixels leave no trace in the queue, so allow the pipeline to empty.
   task automatic settle();
      drain_results();
      repeat (6) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(input fb_regs_type s);
      settle();
      write_register(CSR_SCREEN_WIDTH,  CSR_W'(s.screen_width));
      write_register(CSR_SCREEN_HEIGHT, CSR_W'(s.screen_height));
      write_register(CSR_ROW_PITCH,     CSR_W'(s.row_pitch));
      write_register(CSR_BITS_PER_PIX,  CSR_W'(s.depth));
      write_register(CSR_RED_LAYOUT,    CSR_W'(s.red_layout));
      write_register(CSR_GREEN_LAYOUT,  CSR_W'(s.green_layout));
      write_register(CSR_BLUE_LAYOUT,   CSR_W'(s.blue_layout));
      write_register(CSR_IMAGE_WIDTH,   CSR_W'(s.image_width));
      @(negedge clock) csr_write <= 1'b0;
      fb = s;
   endtask

   function automatic fb_regs_type make_settings(input int sw, sh, pitch, depth,
                                                 input int rl, gl, bl, iw);
      fb_regs_type s;
      s.screen_width  = DIM_W'(sw);
      s.screen_height = DIM_W'(sh);
      s.row_pitch     = PITCH_W'(pitch);
      s.depth         = BPP_W'(depth);
      s.red_layout    = LAY_W'(rl);
      s.green_layout  = LAY_W'(gl);
      s.blue_layout   = LAY_W'(bl);
      s.image_width   = DIM_W'(iw);
      return s;
   endfunction

   function automatic fb_regs_type random_settings();
      fb_regs_type s;
      case ($urandom_range(0, 7))
         0:       s.screen_width = '0;
         1:       s.screen_width = DIM_W'(16383);
         2:       s.screen_width = DIM_W'(MAX_WIDTH);
         default: s.screen_width = DIM_W'($urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 7))
         0:       s.screen_height = '0;
         1:       s.screen_height = DIM_W'(16383);
         default: s.screen_height = DIM_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
         0:       s.row_pitch = '0;
         1:       s.row_pitch = 16'hFFFF;
         default: s.row_pitch = PITCH_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 9))
         0, 1:    s.depth = BPP_W'($urandom_range(0, 127));
         2, 3, 4: s.depth = BPP_24;
         default: s.depth = BPP_32;
      endcase
      s.red_layout   = LAY_W'($urandom_range(0, 511));
      s.green_layout = LAY_W'($urandom_range(0, 511));
      s.blue_layout  = LAY_W'($urandom_range(0, 511));
      if ($urandom_range(0, 5) == 0) begin
         s.red_layout[3:0]   = 4'd0;
         s.green_layout[3:0] = 4'd0;
         s.blue_layout[3:0]  = 4'd0;
      end
      case ($urandom_range(0, 7))
         0:       s.image_width = '0;
         1:       s.image_width = DIM_W'(16383);
         default: s.image_width = DIM_W'($urandom_range(1, 24));
      endcase
      return s;
   endfunction

   // Registers still at their reset values: zero screen width allows no write.
   task automatic check_reset_state();
      stream_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      stream_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
   endtask

   task automatic check_depths();
      apply_settings(make_settings(4, 2, 16, BPP_32, 0, 0, 0, 4));
      stream_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      stream_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      stream_pixel(8'h80, 8'h01, 8'h7F, 1'b0);
      stream_pixel(8'hAA, 8'h55, 8'hC3, 1'b1);
      apply_settings(make_settings(4, 2, 16, BPP_24, 0, 0, 0, 4));
      stream_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
      stream_pixel(8'h12, 8'h34, 8'h56, 1'b1);
      // Unsupported depths write nothing, but the position still moves.
      apply_settings(make_settings(4, 2, 16, 64, 0, 0, 0, 4));
      stream_pixel(8'h01, 8'h02, 8'h03, 1'b0);
      apply_settings(make_settings(4, 2, 16, 127, 0, 0, 0, 4));
      stream_pixel(8'h04, 8'h05, 8'h06, 1'b1);
   endtask

   task automatic check_channel_layouts();
      // Oversized mask, a zero-size channel among sized ones, and the top shift.
      apply_settings(make_settings(16, 16, 64, BPP_32,
                                   {5'd31, 4'd15}, {5'd9, 4'd0}, {5'd0, 4'd3}, 16));
      stream_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      stream_pixel(8'h7F, 8'hA5, 8'h1F, 1'b0);
      apply_settings(make_settings(16, 16, 64, BPP_32,
                                   {5'd24, 4'd8}, {5'd5, 4'd5}, {5'd17, 4'd1}, 16));
      stream_pixel(8'hC3, 8'hF8, 8'h80, 1'b0);
      stream_pixel(8'h3C, 8'h07, 8'h7F, 1'b1);
   endtask

   // The image is wider and taller than the visible area.
   task automatic check_clipping();
      apply_settings(make_settings(2, 1, 100, BPP_24,
                                   {5'd16, 4'd8}, {5'd8, 4'd8}, {5'd0, 4'd8}, 3));
      for (int i = 0; i < 6; i++)
         stream_pixel(CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                      CHAN_W'($urandom_range(0, 255)), i == 5);
   endtask

   // With a zero image width every pixel starts a new row.
   task automatic check_zero_image_width();
      apply_settings(make_settings(4, 4, 40, BPP_32, 0, 0, 0, 0));
      stream_pixel(8'h11, 8'h22, 8'h33, 1'b0);
      stream_pixel(8'h44, 8'h55, 8'h66, 1'b0);
      stream_pixel(8'h77, 8'h88, 8'h99, 1'b1);
   endtask

   // The widest pitch with one pixel per row, then a long row that runs past
   // the visible width while the row position carries over.
   task automatic check_large_offsets();
      apply_settings(make_settings(16383, 16383, 16'hFFFF, BPP_32,
                                   {5'd16, 4'd8}, {5'd8, 4'd8}, {5'd0, 4'd8}, 1));
      for (int i = 0; i < 24; i++)
         stream_pixel(CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                      CHAN_W'($urandom_range(0, 255)), 1'b0);
      apply_settings(make_settings(8, 16383, 16'hFFFF, BPP_32,
                                   {5'd16, 4'd8}, {5'd8, 4'd8}, {5'd0, 4'd8}, 16383));
      for (int i = 0; i < 24; i++)
         stream_pixel(CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                      CHAN_W'($urandom_range(0, 255)), i == 23);
   endtask

   task automatic check_random_images();
      for (int phase = 0; phase < 6; phase++) begin
         apply_settings(random_settings());
         send_gaps_on    = (phase < 4);
         stall_bursts_on = (phase < 4);
         for (int n = 0; n < 250; n++) begin
            if (phase == 1 && n == 125) drain_results();
            stream_pixel(CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                         CHAN_W'($urandom_range(0, 255)), $urandom_range(0, 31) == 0);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            $error("write item arrived with none expected: offset %h word %h",
                   rsp_byte_offset, rsp_pixel_word);
            error_count++;
         end else begin
            oldest_write = pending_writes.pop_front();
            if (rsp_byte_offset !== oldest_write.byte_offset) begin
               $error("byte_offset: expected %h, actual %h",
                      oldest_write.byte_offset, rsp_byte_offset);
               error_count++;
            end
            if (rsp_pixel_word !== oldest_write.pixel_word) begin
               $error("pixel_word: expected %h, actual %h",
                      oldest_write.pixel_word, rsp_pixel_word);
               error_count++;
            end
            if (rsp_four_bytes !== oldest_write.four_bytes) begin
               $error("four_bytes: expected %b, actual %b",
                      oldest_write.four_bytes, rsp_four_bytes);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      check_reset_state();
      check_depths();
      check_channel_layouts();
      check_clipping();
      check_zero_image_width();
      check_large_offsets();
      check_random_images();
      settle();
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_writes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
